FILE: design/pol_pkg.sv
// Shared types and constants for the positional ordered list.
`timescale 1ns / 1ps
package pol_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_READ   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  position;
      logic [31:0] value;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_data;
      logic [4:0]  entry_count;
   } rsp_item_type;

   // Broadcast from the controller to every cell of the row.
   typedef struct packed {
      cell_op_type      op;
      logic [CNT_W-1:0] pos;
      word_type         word;
      logic             read_en;
      logic [CNT_W-1:0] read_pos;
   } pol_ctrl_type;

endpackage

FILE: design/pol_cell.sv
// One storage cell of the list row: holds a word, shifts with its neighbors.
`timescale 1ns / 1ps
module pol_cell
   import pol_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] cell_index,
   input  pol_ctrl_type     ctrl,
   input  word_type         left_word,
   input  word_type         right_word,
   output word_type         word,
   output word_type         tap
);

   word_type         word_ff;
   word_type         word_in;
   logic [CNT_W-1:0] my_idx;

   assign my_idx = CNT_W'(cell_index);

   always_comb begin
      word_in = word_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            if (my_idx > ctrl.pos) begin
               word_in = left_word;
            end else if (my_idx == ctrl.pos) begin
               word_in = ctrl.word;
            end
         end
         CELL_REMOVE: begin
            if (my_idx >= ctrl.pos) begin
               word_in = right_word;
            end
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // Drive own word onto the read tap only when selected.
   assign tap  = (ctrl.read_en && my_idx == ctrl.read_pos) ? word_ff : '0;

endmodule

FILE: design/positional_ordered_list_core.sv
// Top level of the positional ordered list: controller, cell row, result register.
// The result of an item is presented in the cycle after the item is accepted.
// Throughput: one item per cycle; every operation finishes in a single row update.
// The input stalls only while a finished result is held and the output stalls.
// Reset clears the entry count and the result valid; cell words are not cleared
// and are never read before an insert writes them.
`timescale 1ns / 1ps
module positional_ordered_list_core
   import pol_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // Count and result register.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_item_type     rsp_item_ff;
   rsp_item_type     rsp_item_in;

   logic             accept;
   pol_ctrl_type     ctrl;
   status_type       status;
   logic [31:0]      pos_ext;
   logic [31:0]      cnt_ext;
   word_type         read_word;

   // Cell row wiring.
   word_type         cell_word [CAPACITY];
   word_type         cell_tap  [CAPACITY];

   // Stall the input only while a result waits and the output cannot take it.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pos_ext = 32'(req_item.position);
   assign cnt_ext = 32'(count_ff);

   // Decode the item: status, next count and the command broadcast to the cells.
   always_comb begin
      status        = STATUS_OK;
      count_in      = count_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.pos      = CNT_W'(req_item.position);
      ctrl.word     = DATA_WIDTH'(req_item.value);
      ctrl.read_en  = 1'b0;
      ctrl.read_pos = '0;
      unique case (req_item.kind)
         KIND_INSERT: begin
            // A bad position wins over a full list.
            if (pos_ext > cnt_ext) begin
               status = STATUS_BADPOS;
            end else if (cnt_ext >= 32'(CAPACITY)) begin
               status = STATUS_FULL;
            end else begin
               if (accept) begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         KIND_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               status = STATUS_BADPOS;
            end else begin
               if (accept) begin
                  ctrl.op  = CELL_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         KIND_READ: begin
            if (count_ff == '0) begin
               status = STATUS_EMPTY;
            end else begin
               // Saturate the position to the last entry.
               ctrl.read_en  = 1'b1;
               ctrl.read_pos = (pos_ext < cnt_ext) ? CNT_W'(req_item.position)
                                                   : count_ff - CNT_W'(1);
            end
         end
         KIND_CLEAR: begin
            if (accept) begin
               count_in = '0;
            end
         end
         default: status = STATUS_OK;
      endcase
   end

   // Row of cells; each neighbor hands its word across on insert and remove.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type left_word;
      word_type right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end
      pol_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i]),
         .tap        (cell_tap[i])
      );
   end

   // Merge the read taps; at most one cell drives a nonzero word.
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_tap[i];
      end
   end

   // Build the result and advance the output register.
   always_comb begin
      rsp_item_in.status      = status;
      rsp_item_in.read_data   = 32'(read_word);
      rsp_item_in.entry_count = 5'(count_in);
      rsp_valid_in            = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the payload until a new item replaces it.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(CAPACITY))
      else $error("entry count above capacity");

   a_count_shown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_item_ff.entry_count) == 32'(5'(count_ff)))
      else $error("result count differs from list count");

   a_error_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && status != STATUS_OK) |=> count_ff == $past(count_ff))
      else $error("failed operation changed the count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.kind == KIND_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the list");
`endif

endmodule
